// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/lpmd_pkg.sv =====
// Types and constants of the length-prefixed message deframer.
package lpmd_pkg;

	// input function codes
	localparam logic FUNC_BYTE    = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	// result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	// length field: four bytes that count themselves
	localparam int unsigned LEN_FIELD_BYTES = 4;
	localparam logic [31:0] LEN_MIN         = 32'(LEN_FIELD_BYTES);
	localparam logic [1:0]  LEN_LAST_IDX    = 2'(LEN_FIELD_BYTES - 1);
	localparam logic [31:0] MAX_MSG_LEN_RST = 32'd1073741824;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] msg_type;
		logic [7:0] payload_byte;
		logic       first_byte;
		logic       last_byte;
	} out_item_t;

endpackage

// ===== rtl/core/lpmd_framer.sv =====
// Framing state machine: header collection, length check, payload tagging.
`include "assert_macros.svh"

module lpmd_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  lpmd_pkg::in_item_t  item,
	input  logic [31:0]         max_msg_len,
	output logic                res_valid,
	output lpmd_pkg::out_item_t res
);

	typedef enum logic [1:0] {
		PH_TYPE    = 2'd0,
		PH_LEN     = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  type_hold_q, type_hold_d;
	logic [31:0] length_shift_q, length_shift_d;
	logic [1:0]  header_count_q, header_count_d;
	logic [31:0] payload_left_q, payload_left_d;
	logic        first_pending_q, first_pending_d;
	logic        error_stuck_q, error_stuck_d;

	logic [31:0] len_full;
	logic [31:0] len_body;
	logic [31:0] left_dec;

	assign len_full = {length_shift_q[23:0], item.data_byte};
	assign len_body = len_full - lpmd_pkg::LEN_MIN;
	assign left_dec = payload_left_q - 32'd1;

	// decode one transaction against the current framing state
	always_comb begin
		phase_d         = phase_q;
		type_hold_d     = type_hold_q;
		length_shift_d  = length_shift_q;
		header_count_d  = header_count_q;
		payload_left_d  = payload_left_q;
		first_pending_d = first_pending_q;
		error_stuck_d   = error_stuck_q;
		res_valid       = 1'b0;
		res.kind        = lpmd_pkg::KIND_PAYLOAD;
		res.msg_type    = type_hold_q;
		res.payload_byte = 8'd0;
		res.first_byte  = 1'b0;
		res.last_byte   = 1'b0;

		if (item.func == lpmd_pkg::FUNC_RESTART) begin
			// clear all framing state and the error
			phase_d         = PH_TYPE;
			type_hold_d     = 8'd0;
			length_shift_d  = 32'd0;
			header_count_d  = 2'd0;
			payload_left_d  = 32'd0;
			first_pending_d = 1'b0;
			error_stuck_d   = 1'b0;
		end else if (!error_stuck_q) begin
			case (phase_q)
				PH_LEN: begin
					length_shift_d = len_full;
					if (header_count_q != lpmd_pkg::LEN_LAST_IDX) begin
						header_count_d = header_count_q + 2'd1;
					end else begin
						header_count_d = 2'd0;
						phase_d        = PH_TYPE;
						res_valid      = 1'b1;
						if (len_full < lpmd_pkg::LEN_MIN || len_full > max_msg_len) begin
							// bad length: report once and drop bytes until restart
							error_stuck_d = 1'b1;
							res.kind      = lpmd_pkg::KIND_ERROR;
						end else begin
							payload_left_d = len_body;
							if (len_body == 32'd0) begin
								res.kind      = lpmd_pkg::KIND_EMPTY;
								res.last_byte = 1'b1;
							end else begin
								res_valid       = 1'b0;
								first_pending_d = 1'b1;
								phase_d         = PH_PAYLOAD;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					// pass the byte through, mark first and last
					res_valid        = 1'b1;
					res.payload_byte = item.data_byte;
					res.first_byte   = first_pending_q;
					res.last_byte    = (left_dec == 32'd0);
					first_pending_d  = 1'b0;
					payload_left_d   = left_dec;
					if (left_dec == 32'd0) begin
						phase_d = PH_TYPE;
					end
				end
				default: begin
					// take the type byte and start the length field
					type_hold_d     = item.data_byte;
					length_shift_d  = 32'd0;
					header_count_d  = 2'd0;
					payload_left_d  = 32'd0;
					first_pending_d = 1'b0;
					phase_d         = PH_LEN;
				end
			endcase
		end
	end

	// hold framing state, advance on each processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_TYPE;
			type_hold_q     <= 8'd0;
			length_shift_q  <= 32'd0;
			header_count_q  <= 2'd0;
			payload_left_q  <= 32'd0;
			first_pending_q <= 1'b0;
			error_stuck_q   <= 1'b0;
		end else if (step) begin
			phase_q         <= phase_d;
			type_hold_q     <= type_hold_d;
			length_shift_q  <= length_shift_d;
			header_count_q  <= header_count_d;
			payload_left_q  <= payload_left_d;
			first_pending_q <= first_pending_d;
			error_stuck_q   <= error_stuck_d;
		end
	end

	`ASSERT_IMPLIES(a_stuck_in_type, clk, arst_n, error_stuck_q, phase_q == PH_TYPE)
	`ASSERT_IMPLIES(a_count_in_len, clk, arst_n, header_count_q != 2'd0, phase_q == PH_LEN)
	`ASSERT_IMPLIES(a_payload_left, clk, arst_n, phase_q == PH_PAYLOAD, payload_left_q != 32'd0)

endmodule

// ===== rtl/core/length_prefixed_message_deframer_top.sv =====
// Top level of the length-prefixed message deframer.
//
// Input channel (in_valid/in_ready/in_data) carries one transaction per byte:
// a stream byte or a restart. Each message is a type byte and a big-endian
// 32-bit length that counts its own four bytes; payload bytes follow.
// Output channel (out_valid/out_ready/out_data) carries at most one result per
// input transaction: a tagged payload byte, an empty-message marker, or a
// length error. After an error stream bytes are dropped until a restart.
// cfg_wr_en/cfg_wr_data write max_msg_len; write it only while idle.
// An input is held in the input register and its result in the output register, which drives out_valid.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single framing stage between the input register and the output register.
// Reset clears the framing state and the error, and sets max_msg_len to 2^30.
// When the receiver stalls, the output register holds its result; the input
// register takes one more transaction, then in_ready drops until the output
// register frees.
`include "assert_macros.svh"

module length_prefixed_message_deframer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lpmd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lpmd_pkg::out_item_t out_data,
	input  logic                cfg_wr_en,
	input  logic [31:0]         cfg_wr_data
);

	logic                valid_s1;
	lpmd_pkg::in_item_t  item_s1;
	logic                out_valid_q;
	lpmd_pkg::out_item_t out_q;
	logic [31:0]         max_msg_len_q;
	logic                out_free;
	logic                advance;
	logic                res_valid;
	lpmd_pkg::out_item_t res;

	assign out_free  = !out_valid_q || out_ready;
	assign advance   = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// hold the configured maximum length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_msg_len_q <= lpmd_pkg::MAX_MSG_LEN_RST;
		end else if (cfg_wr_en) begin
			max_msg_len_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	lpmd_framer u_framer (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.max_msg_len (max_msg_len_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	// output register: load a result when free, hold it while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	`ASSERT_IMPLIES(a_no_overrun, clk, arst_n, valid_s1 && !out_free, !in_ready)
	`ASSERT_IMPLIES(a_error_clean, clk, arst_n,
		out_valid_q && out_q.kind == lpmd_pkg::KIND_ERROR,
		out_q.payload_byte == 8'd0 && !out_q.first_byte && !out_q.last_byte)
	`ASSERT_IMPLIES(a_empty_marks, clk, arst_n,
		out_valid_q && out_q.kind == lpmd_pkg::KIND_EMPTY,
		out_q.last_byte && !out_q.first_byte && out_q.payload_byte == 8'd0)

endmodule
